// ----- hw/rtl/nsf_pkg.sv -----
// Shared types, character constants and helper functions for the NMEA sentence framer.
package nsf_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  localparam logic [7:0] LEN_SAT   = 8'hFF;
  localparam logic [4:0] COMMA_SAT = 5'd30;
  localparam int         MASK_W    = 16;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_GGA   = 2'd1;
  localparam logic [1:0] KIND_RMC   = 2'd2;

  typedef struct packed {
    logic [1:0]        sentence_kind;
    logic              checksum_ok;
    logic              too_long;
    logic [4:0]        field_count;
    logic [MASK_W-1:0] filled_mask;
    logic [7:0]        sentence_length;
  } nsf_report_t;

  // Tag characters after '$': position 1..5.
  function automatic logic [7:0] gga_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h4E; // N
      3'd3:    c = 8'h47; // G
      3'd4:    c = 8'h47; // G
      3'd5:    c = 8'h41; // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rmc_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h4E; // N
      3'd3:    c = 8'h52; // R
      3'd4:    c = 8'h4D; // M
      3'd5:    c = 8'h43; // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Bit 4 set: not a hex digit. Bits 3:0: digit value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b0, 4'(c - CH_0)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b0, 4'(c - CH_UA + 8'd10)};
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      r = {1'b0, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/nsf_tracker.sv -----
// Input byte register and per-sentence tracking state; builds the report on LF.
module nsf_tracker #(
  parameter int MAX_LEN     = 128,
  parameter int FIELD_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          byte_in,
  input  logic                space,
  output logic                hold,
  output logic                push,
  output nsf_pkg::nsf_report_t report
);
  import nsf_pkg::*;

  typedef enum logic [1:0] {PH_BODY, PH_HI, PH_LO, PH_DONE} phase_t;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;

  logic              in_sent_r,  in_sent_nxt;
  phase_t            phase_r,    phase_nxt;
  logic [7:0]        xor_r,      xor_nxt;
  logic [7:0]        rsum_r,     rsum_nxt;
  logic              hexv_r,     hexv_nxt;
  logic [7:0]        count_r,    count_nxt;
  logic              gga_r,      gga_nxt;
  logic              rmc_r,      rmc_nxt;
  logic [4:0]        comma_r,    comma_nxt;
  logic              filled_r,   filled_nxt;
  logic [MASK_W-1:0] mask_r,     mask_nxt;

  logic              is_lf;
  logic              adv;
  logic [MASK_W-1:0] mask_commit;
  logic [4:0]        hd;
  logic [7:0]        b;

  assign b     = s1_byte_r;
  assign is_lf = in_sent_r && (b == CH_LF);
  assign adv   = s1_valid_r && (!is_lf || space);
  assign hold  = s1_valid_r && !adv;
  assign push  = adv && is_lf;
  assign hd    = hex_digit(b);

  // Close the current field into the mask.
  always_comb begin
    mask_commit = mask_r;
    if (filled_r && (comma_r < 5'(FIELD_SLOTS))) begin
      mask_commit = mask_r | (MASK_W'(1) << comma_r[3:0]);
    end
  end

  always_comb begin
    in_sent_nxt = in_sent_r;
    phase_nxt   = phase_r;
    xor_nxt     = xor_r;
    rsum_nxt    = rsum_r;
    hexv_nxt    = hexv_r;
    count_nxt   = count_r;
    gga_nxt     = gga_r;
    rmc_nxt     = rmc_r;
    comma_nxt   = comma_r;
    filled_nxt  = filled_r;
    mask_nxt    = mask_r;
    if (!in_sent_r) begin
      if (b == CH_DOLLAR) begin
        in_sent_nxt = 1'b1;
        phase_nxt   = PH_BODY;
        xor_nxt     = '0;
        rsum_nxt    = '0;
        hexv_nxt    = 1'b0;
        count_nxt   = 8'd1;
        gga_nxt     = 1'b1;
        rmc_nxt     = 1'b1;
        comma_nxt   = '0;
        filled_nxt  = 1'b1;
        mask_nxt    = '0;
      end
    end else begin
      if (count_r != LEN_SAT) begin
        count_nxt = count_r + 8'd1;
      end
      if (count_r >= 8'd1 && count_r <= 8'd5) begin
        if (b != gga_char(count_r[2:0])) gga_nxt = 1'b0;
        if (b != rmc_char(count_r[2:0])) rmc_nxt = 1'b0;
      end
      case (phase_r)
        PH_BODY: begin
          if (b == CH_STAR || b == CH_CR || b == CH_LF) begin
            mask_nxt  = mask_commit;
            phase_nxt = (b == CH_STAR) ? PH_HI : PH_DONE;
          end else begin
            xor_nxt = xor_r ^ b;
            if (b == CH_COMMA) begin
              mask_nxt   = mask_commit;
              if (comma_r < COMMA_SAT) comma_nxt = comma_r + 5'd1;
              filled_nxt = 1'b0;
            end else begin
              filled_nxt = 1'b1;
            end
          end
        end
        PH_HI: begin
          if (!hd[4]) begin
            rsum_nxt  = {hd[3:0], 4'h0};
            phase_nxt = PH_LO;
          end else begin
            hexv_nxt  = 1'b0;
            phase_nxt = PH_DONE;
          end
        end
        PH_LO: begin
          if (!hd[4]) begin
            rsum_nxt = rsum_r | {4'h0, hd[3:0]};
            hexv_nxt = 1'b1;
          end else begin
            hexv_nxt = 1'b0;
          end
          phase_nxt = PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    report.sentence_kind   = gga_nxt ? KIND_GGA : (rmc_nxt ? KIND_RMC : KIND_OTHER);
    report.checksum_ok     = hexv_nxt && (rsum_nxt == xor_nxt);
    report.too_long        = count_nxt >= 8'(MAX_LEN - 1);
    report.field_count     = comma_nxt + 5'd1;
    report.filled_mask     = mask_nxt;
    report.sentence_length = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) s1_byte_r <= byte_in;
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      in_sent_r  <= 1'b0;
      phase_r    <= PH_BODY;
      xor_r      <= '0;
      rsum_r     <= '0;
      hexv_r     <= 1'b0;
      count_r    <= '0;
      gga_r      <= 1'b0;
      rmc_r      <= 1'b0;
      comma_r    <= '0;
      filled_r   <= 1'b0;
      mask_r     <= '0;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        if (is_lf) begin
          in_sent_r <= 1'b0;
          phase_r   <= PH_BODY;
          xor_r     <= '0;
          rsum_r    <= '0;
          hexv_r    <= 1'b0;
          count_r   <= '0;
          gga_r     <= 1'b0;
          rmc_r     <= 1'b0;
          comma_r   <= '0;
          filled_r  <= 1'b0;
          mask_r    <= '0;
        end else begin
          in_sent_r <= in_sent_nxt;
          phase_r   <= phase_nxt;
          xor_r     <= xor_nxt;
          rsum_r    <= rsum_nxt;
          hexv_r    <= hexv_nxt;
          count_r   <= count_nxt;
          gga_r     <= gga_nxt;
          rmc_r     <= rmc_nxt;
          comma_r   <= comma_nxt;
          filled_r  <= filled_nxt;
          mask_r    <= mask_nxt;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/nsf_out_buf.sv -----
// Result register with a skid entry behind it.
module nsf_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nsf_pkg::nsf_report_t report_in,
  output logic                space,
  output logic                out_valid,
  input  logic                out_stall,
  output nsf_pkg::nsf_report_t report_out
);
  import nsf_pkg::*;

  logic        head_valid_r;
  nsf_report_t head_r;
  logic        skid_valid_r;
  nsf_report_t skid_r;
  logic        pop;

  assign pop        = head_valid_r && !out_stall;
  assign space      = !skid_valid_r || pop;
  assign out_valid  = head_valid_r;
  assign report_out = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop || !head_valid_r) begin
        if (skid_valid_r) begin
          head_r       <= skid_r;
          head_valid_r <= 1'b1;
          skid_valid_r <= push;
          if (push) skid_r <= report_in;
        end else begin
          head_valid_r <= push;
          if (push) head_r <= report_in;
        end
      end else if (push) begin
        skid_r       <= report_in;
        skid_valid_r <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/nmea_sentence_framer_unit.sv -----
// Top level of the NMEA 0183 sentence framer and checksum checker.
//
// Takes one received character per item and emits one report per LF that
// ends a sentence opened by '$'. Every item is held in an input
// register; the tracking logic then updates the sentence state (body XOR,
// hex checksum digits, GNGGA/GNRMC tag match, saturating length, comma count
// and non-empty field mask) in a single pass, and on LF the report is written
// to the result register. out_valid rises once the LF's report is in the
// result register, later only while earlier reports still wait; one item
// is accepted every cycle while in_stall is low. A skid entry behind the result
// register lets the input keep flowing while a report waits; in_stall only
// rises when both the result register and the skid entry hold reports and
// the pending input byte is another LF. Bytes outside a sentence other than
// '$' produce nothing. too_long flags sentences of at least MAX_LEN - 1
// bytes; filled_mask covers fields 0 to FIELD_SLOTS - 1.
module nmea_sentence_framer_unit #(
  parameter int MAX_LEN     = 128,
  parameter int FIELD_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_sentence_kind,
  output logic        out_checksum_ok,
  output logic        out_too_long,
  output logic [4:0]  out_field_count,
  output logic [15:0] out_filled_mask,
  output logic [7:0]  out_sentence_length
);
  import nsf_pkg::*;

  logic        hold;
  logic        take;
  logic        push;
  logic        space;
  nsf_report_t rpt_new;
  nsf_report_t rpt_out;

  // Input register is free unless its byte (an LF) cannot reach the buffer.
  assign in_stall = hold;
  assign take     = in_valid && !hold;

  nsf_tracker #(
    .MAX_LEN     (MAX_LEN),
    .FIELD_SLOTS (FIELD_SLOTS)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_rx_byte),
    .space   (space),
    .hold    (hold),
    .push    (push),
    .report  (rpt_new)
  );

  nsf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .report_in  (rpt_new),
    .space      (space),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .report_out (rpt_out)
  );

  assign out_sentence_kind   = rpt_out.sentence_kind;
  assign out_checksum_ok     = rpt_out.checksum_ok;
  assign out_too_long        = rpt_out.too_long;
  assign out_field_count     = rpt_out.field_count;
  assign out_filled_mask     = rpt_out.filled_mask;
  assign out_sentence_length = rpt_out.sentence_length;

endmodule

// ----- tb/sv/nsf_report_checker.sv -----
// Sentence report checker: predicts framer reports from accepted bytes and compares them.
`timescale 1ns / 1ps

module nsf_report_checker #(
  parameter int MAX_LEN     = 128,
  parameter int FIELD_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_sentence_kind,
  input  logic        out_checksum_ok,
  input  logic        out_too_long,
  input  logic [4:0]  out_field_count,
  input  logic [15:0] out_filled_mask,
  input  logic [7:0]  out_sentence_length,
  output int          fail_count,
  output int          pending
);
  import nsf_pkg::*;

  typedef enum logic [1:0] {PH_BODY, PH_HI, PH_LO, PH_DONE} sum_phase_t;

  localparam logic [39:0] GGA_TAG = "GNGGA";
  localparam logic [39:0] RMC_TAG = "GNRMC";

  logic        in_frame       = 1'b0;
  sum_phase_t  phase          = PH_BODY;
  logic [7:0]  body_xor       = '0;
  logic [7:0]  star_sum       = '0;
  logic        sum_valid      = 1'b0;
  logic [7:0]  len_cnt        = '0;
  logic        gga_ok         = 1'b0;
  logic        rmc_ok         = 1'b0;
  logic [4:0]  commas         = '0;
  logic        field_has_data = 1'b0;
  logic [15:0] mask           = '0;

  nsf_report_t report_q[$];
  int          errs = 0;
  int          pend = 0;

  assign fail_count = errs;
  assign pending    = pend;

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  task automatic clear_frame();
    in_frame       = 1'b0;
    phase          = PH_BODY;
    body_xor       = '0;
    star_sum       = '0;
    sum_valid      = 1'b0;
    len_cnt        = '0;
    gga_ok         = 1'b0;
    rmc_ok         = 1'b0;
    commas         = '0;
    field_has_data = 1'b0;
    mask           = '0;
  endtask

  task automatic close_field();
    if (field_has_data && commas < FIELD_SLOTS && commas < 16) mask[commas[3:0]] = 1'b1;
  endtask

  task automatic take_byte(input logic [7:0] b);
    logic [7:0]  pos;
    logic [4:0]  nib;
    nsf_report_t rep;
    if (!in_frame) begin
      if (b == CH_DOLLAR) begin
        clear_frame();
        in_frame       = 1'b1;
        len_cnt        = 8'd1;
        gga_ok         = 1'b1;
        rmc_ok         = 1'b1;
        field_has_data = 1'b1;
      end
    end else begin
      pos = len_cnt;
      if (len_cnt != LEN_SAT) len_cnt = len_cnt + 8'd1;
      if (pos >= 1 && pos <= 5) begin
        if (b != GGA_TAG[8*(5-pos) +: 8]) gga_ok = 1'b0;
        if (b != RMC_TAG[8*(5-pos) +: 8]) rmc_ok = 1'b0;
      end
      nib = nibble_of(b);
      case (phase)
        PH_BODY: begin
          if (b == CH_STAR || b == CH_CR || b == CH_LF) begin
            close_field();
            phase = (b == CH_STAR) ? PH_HI : PH_DONE;
          end else begin
            body_xor = body_xor ^ b;
            if (b == CH_COMMA) begin
              close_field();
              if (commas < COMMA_SAT) commas = commas + 5'd1;
              field_has_data = 1'b0;
            end else begin
              field_has_data = 1'b1;
            end
          end
        end
        PH_HI: begin
          if (nib[4]) begin
            star_sum = {nib[3:0], 4'h0};
            phase    = PH_LO;
          end else begin
            sum_valid = 1'b0;
            phase     = PH_DONE;
          end
        end
        PH_LO: begin
          if (nib[4]) begin
            star_sum[3:0] = nib[3:0];
            sum_valid     = 1'b1;
          end else begin
            sum_valid = 1'b0;
          end
          phase = PH_DONE;
        end
        default: ;
      endcase
      if (b == CH_LF) begin
        rep.sentence_kind   = gga_ok ? KIND_GGA : (rmc_ok ? KIND_RMC : KIND_OTHER);
        rep.checksum_ok     = sum_valid && (star_sum == body_xor);
        rep.too_long        = (int'(len_cnt) >= MAX_LEN - 1);
        rep.field_count     = commas + 5'd1;
        rep.filled_mask     = mask;
        rep.sentence_length = len_cnt;
        report_q.push_back(rep);
        clear_frame();
      end
    end
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errs++;
    end
  endtask

  // results are compared before the same edge's input is folded in
  always @(posedge clk) begin
    nsf_report_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("unexpected report: kind %0d length %0d", out_sentence_kind,
                 out_sentence_length);
          errs++;
        end else begin
          want = report_q.pop_front();
          check_field("sentence_kind", want.sentence_kind, out_sentence_kind);
          check_field("checksum_ok", want.checksum_ok, out_checksum_ok);
          check_field("too_long", want.too_long, out_too_long);
          check_field("field_count", want.field_count, out_field_count);
          check_field("filled_mask", want.filled_mask, out_filled_mask);
          check_field("sentence_length", want.sentence_length, out_sentence_length);
        end
      end
      if (in_valid && !in_stall) take_byte(in_rx_byte);
      pend = report_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_nmea_sentence_framer_unit.sv -----
// Top of the sentence framer testbench: byte stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module tb_nmea_sentence_framer_unit;
  import nsf_pkg::*;

  // Worst run: ~1500 bytes, short sentences, rare 300-byte ones, both sides
  // idling. RUN_LIMIT is set well above what such a run needs.
  localparam int RUN_LIMIT = 400000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_sentence_kind;
  logic        out_checksum_ok;
  logic        out_too_long;
  logic [4:0]  out_field_count;
  logic [15:0] out_filled_mask;
  logic [7:0]  out_sentence_length;

  int fail_count;
  int pending;
  int cycles         = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  // bytes of the sentence under construction and the XOR of its body
  logic [7:0] frame_q[$];
  logic [7:0] body_sum;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nmea_sentence_framer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sentence_kind   (out_sentence_kind),
    .out_checksum_ok     (out_checksum_ok),
    .out_too_long        (out_too_long),
    .out_field_count     (out_field_count),
    .out_filled_mask     (out_filled_mask),
    .out_sentence_length (out_sentence_length)
  );

  nsf_report_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sentence_kind   (out_sentence_kind),
    .out_checksum_ok     (out_checksum_ok),
    .out_too_long        (out_too_long),
    .out_field_count     (out_field_count),
    .out_filled_mask     (out_filled_mask),
    .out_sentence_length (out_sentence_length),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // Watchdog: a hung handshake or a lost report ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall decided fresh every cycle at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high into the next item unless a gap is drawn.
  task automatic send_byte(input logic [7:0] b);
    if (src_idle_pct > 0) begin
      while ($urandom_range(99) < src_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    if (nib < 10) return 8'h30 + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  // Body content: mostly printable, some '$', some arbitrary bytes (zero
  // included) that carry no delimiter meaning.
  function automatic logic [7:0] body_char();
    int         r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 75) return 8'($urandom_range(8'h5A, 8'h2D));
    if (r < 83) return CH_DOLLAR;
    do c = 8'($urandom_range(255));
    while (c == CH_STAR || c == CH_CR || c == CH_LF || c == CH_COMMA);
    return c;
  endfunction

  task automatic push_body(input logic [7:0] c);
    frame_q.push_back(c);
    body_sum = body_sum ^ c;
  endtask

  task automatic push_sum(input logic [7:0] s);
    frame_q.push_back(hex_char(s[7:4], 1'($urandom_range(1))));
    frame_q.push_back(hex_char(s[3:0], 1'($urandom_range(1))));
  endtask

  // Builds one sentence: a tag (real, near miss, random or short), a number
  // of comma fields, then one of several checksum tails.
  task automatic build_sentence();
    logic [39:0] tag;
    logic [7:0]  c;
    logic        lengthy;
    logic        ended;
    int          r, k, j, n_tag, n_fields, flen;
    frame_q.delete();
    frame_q.push_back(CH_DOLLAR);
    body_sum = 8'h00;
    ended    = 1'b0;

    r     = $urandom_range(99);
    tag   = (r < 35) ? "GNGGA" : "GNRMC";
    n_tag = 5;
    if (r >= 70 && r < 85) begin
      // near miss: one tag letter replaced
      tag[8*$urandom_range(4) +: 8] = body_char();
    end else if (r >= 85) begin
      n_tag = $urandom_range(5);
      for (k = 0; k < 5; k++) tag[8*k +: 8] = body_char();
    end
    for (k = 0; k < n_tag; k++) push_body(tag[8*(4-k) +: 8]);

    // a few long sentences push the length past the limit, some past saturation
    lengthy = ($urandom_range(99) < 3);
    r = $urandom_range(99);
    if (lengthy)      n_fields = $urandom_range(20, 14);
    else if (r < 85)  n_fields = $urandom_range(10);
    else if (r < 95)  n_fields = $urandom_range(20, 15);
    else              n_fields = $urandom_range(36, 29);
    for (k = 0; k < n_fields; k++) begin
      push_body(CH_COMMA);
      if (lengthy)                       flen = $urandom_range(16, 8);
      else if ($urandom_range(99) < 35)  flen = 0;
      else                               flen = $urandom_range(4, 1);
      for (j = 0; j < flen; j++) push_body(body_char());
    end

    r = $urandom_range(99);
    if (r < 55) begin
      frame_q.push_back(CH_STAR);
      push_sum(body_sum);
    end else if (r < 65) begin
      frame_q.push_back(CH_STAR);
      push_sum(body_sum ^ 8'($urandom_range(255, 1)));
    end else if (r < 75) begin
      // no star: CR or LF ends the body
    end else if (r < 83) begin
      // one digit slot holds a non-hex byte
      frame_q.push_back(CH_STAR);
      do c = 8'($urandom_range(255));
      while (is_hex(c) || c == CH_LF);
      if ($urandom_range(1)) begin
        frame_q.push_back(c);
        frame_q.push_back(hex_char(4'($urandom_range(15)), 1'b1));
      end else begin
        frame_q.push_back(hex_char(4'($urandom_range(15)), 1'b0));
        frame_q.push_back(c);
      end
    end else if (r < 91) begin
      // LF lands in a digit slot
      frame_q.push_back(CH_STAR);
      if ($urandom_range(1)) frame_q.push_back(hex_char(body_sum[7:4], 1'b1));
      frame_q.push_back(CH_LF);
      ended = 1'b1;
    end else begin
      // trailing bytes after a good checksum, commas among them
      frame_q.push_back(CH_STAR);
      push_sum(body_sum);
      for (k = $urandom_range(6, 1); k > 0; k--) begin
        do c = ($urandom_range(3) == 0) ? CH_COMMA : 8'($urandom_range(255));
        while (c == CH_LF);
        frame_q.push_back(c);
      end
    end
    if (!ended) begin
      if ($urandom_range(1)) frame_q.push_back(CH_CR);
      frame_q.push_back(CH_LF);
    end
  endtask

  // Noise between sentences: ignored bytes, and now and then a stray '$'
  // that opens a sentence the next one breaks into.
  task automatic send_noise();
    int k;
    if ($urandom_range(99) < 25) begin
      for (k = $urandom_range(3, 1); k > 0; k--) begin
        send_byte(($urandom_range(99) < 5) ? CH_DOLLAR : 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct);
    int sent, frames;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent   = 0;
    frames = 0;
    while (sent < 350 || frames < 14) begin
      send_noise();
      build_sentence();
      foreach (frame_q[i]) send_byte(frame_q[i]);
      sent   += frame_q.size();
      frames++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: ignored bytes outside a sentence (LF among them), both tags
    // with good checksums (one with a lower-case hex digit), a '$' and a zero
    // byte in the body with no star, and nothing after the star.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_text("$GNGGA*48\n");
    send_text("$GNRMC,B*3b\n");
    send_text("$A$,");
    send_byte(8'h00);
    send_byte(CH_CR);
    send_text("\n$*\n");

    // Random sentences under each idling pattern.
    run_phase(0, 0);
    run_phase(55, 0);
    run_phase(0, 55);
    run_phase(14, 14);

    in_valid       <= 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
